@@ src/mpeg_audio_frame_header_decode_unit_defines.svh @@
// Assertion macros for the MPEG audio frame header decode unit.
`ifndef MPEG_AUDIO_FRAME_HEADER_DECODE_UNIT_DEFINES_SVH
`define MPEG_AUDIO_FRAME_HEADER_DECODE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define MAFHD_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("%m: assertion failed");
`define MAFHD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("%m: assertion failed");
`else
`define MAFHD_ASSERT_SAME(label, clk, rst, cond, prop)
`define MAFHD_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

@@ src/mafhd_pkg.sv @@
package mafhd_pkg;

   localparam int DIV_BITS = 4;
   localparam int REM_W    = 16;
   localparam int QUO_W    = 12;
   localparam int PROD_W   = 16;
   localparam int NUM_W    = 26;
   localparam logic [9:0] KILO = 10'd1000;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_SYNC    = 3'd1,
      ST_RSVD_VER   = 3'd2,
      ST_RSVD_LAYER = 3'd3,
      ST_ZERO_RATE  = 3'd4,
      ST_RSVD_FREQ  = 3'd5
   } status_type;

   localparam logic [1:0] VER_RESERVED = 2'd1;
   localparam logic [1:0] VER_MPEG1    = 2'd3;
   localparam logic [1:0] LAYER_I      = 2'd0;
   localparam logic [1:0] LAYER_II     = 2'd1;
   localparam logic [1:0] LAYER_NONE   = 2'd3;
   localparam logic [1:0] FREQ_NONE    = 2'd3;

   typedef struct packed {
      status_type  status;
      logic [1:0]  ver;
      logic [1:0]  layer;
      logic        crc;
      logic        pad;
      logic [8:0]  kbps;
      logic [15:0] hz;
   } info_type;

   function automatic logic [8:0] kbps_lookup(input logic fam, input logic [1:0] layer,
                                              input logic [3:0] idx);
      logic [8:0] v;
      v = 9'd0;
      if (!fam && layer == LAYER_I) begin
         unique case (idx)
            4'd1: v = 9'd32;   4'd2: v = 9'd64;   4'd3: v = 9'd96;   4'd4: v = 9'd128;
            4'd5: v = 9'd160;  4'd6: v = 9'd192;  4'd7: v = 9'd224;  4'd8: v = 9'd256;
            4'd9: v = 9'd288;  4'd10: v = 9'd320; 4'd11: v = 9'd352; 4'd12: v = 9'd384;
            4'd13: v = 9'd416; 4'd14: v = 9'd448; default: v = 9'd0;
         endcase
      end else if (!fam && layer == LAYER_II) begin
         unique case (idx)
            4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;   4'd4: v = 9'd64;
            4'd5: v = 9'd80;   4'd6: v = 9'd96;   4'd7: v = 9'd112;  4'd8: v = 9'd128;
            4'd9: v = 9'd160;  4'd10: v = 9'd192; 4'd11: v = 9'd224; 4'd12: v = 9'd256;
            4'd13: v = 9'd320; 4'd14: v = 9'd384; default: v = 9'd0;
         endcase
      end else if (!fam) begin
         unique case (idx)
            4'd1: v = 9'd32;   4'd2: v = 9'd40;   4'd3: v = 9'd48;   4'd4: v = 9'd56;
            4'd5: v = 9'd64;   4'd6: v = 9'd80;   4'd7: v = 9'd96;   4'd8: v = 9'd112;
            4'd9: v = 9'd128;  4'd10: v = 9'd160; 4'd11: v = 9'd192; 4'd12: v = 9'd224;
            4'd13: v = 9'd256; 4'd14: v = 9'd320; default: v = 9'd0;
         endcase
      end else if (layer == LAYER_I) begin
         unique case (idx)
            4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;   4'd4: v = 9'd64;
            4'd5: v = 9'd80;   4'd6: v = 9'd96;   4'd7: v = 9'd112;  4'd8: v = 9'd128;
            4'd9: v = 9'd144;  4'd10: v = 9'd160; 4'd11: v = 9'd176; 4'd12: v = 9'd192;
            4'd13: v = 9'd224; 4'd14: v = 9'd256; default: v = 9'd0;
         endcase
      end else begin
         unique case (idx)
            4'd1: v = 9'd8;    4'd2: v = 9'd16;   4'd3: v = 9'd24;   4'd4: v = 9'd32;
            4'd5: v = 9'd40;   4'd6: v = 9'd48;   4'd7: v = 9'd56;   4'd8: v = 9'd64;
            4'd9: v = 9'd80;   4'd10: v = 9'd96;  4'd11: v = 9'd112; 4'd12: v = 9'd128;
            4'd13: v = 9'd144; 4'd14: v = 9'd160; default: v = 9'd0;
         endcase
      end
      return v;
   endfunction

   function automatic logic [15:0] hz_lookup(input logic [1:0] ver, input logic [1:0] idx);
      logic [15:0] v;
      v = 16'd0;
      unique case ({ver, idx})
         4'b00_00: v = 16'd11025;
         4'b00_01: v = 16'd12000;
         4'b00_10: v = 16'd8000;
         4'b10_00: v = 16'd22050;
         4'b10_01: v = 16'd24000;
         4'b10_10: v = 16'd16000;
         4'b11_00: v = 16'd44100;
         4'b11_01: v = 16'd48000;
         4'b11_10: v = 16'd32000;
         default:  v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] coef_lookup(input logic fam, input logic [1:0] layer);
      logic [7:0] v;
      if (layer == LAYER_I) begin
         v = 8'd12;
      end else if (layer == LAYER_II || !fam) begin
         v = 8'd144;
      end else begin
         v = 8'd72;
      end
      return v;
   endfunction

endpackage

@@ src/mafhd_div_step.sv @@
module mafhd_div_step (
   input  logic [mafhd_pkg::REM_W-1:0]    rem_in,
   input  logic [mafhd_pkg::DIV_BITS-1:0] low_in,
   input  logic [mafhd_pkg::REM_W-1:0]    divisor,
   output logic [mafhd_pkg::REM_W-1:0]    rem_out,
   output logic [mafhd_pkg::DIV_BITS-1:0] quo_out
);
   import mafhd_pkg::*;

   always_comb begin
      logic [REM_W:0] r;
      r = {1'b0, rem_in};
      quo_out = '0;
      for (int i = DIV_BITS - 1; i >= 0; i--) begin
         r = {r[REM_W-1:0], low_in[i]};
         if (r >= {1'b0, divisor}) begin
            r = r - {1'b0, divisor};
            quo_out[i] = 1'b1;
         end
      end
      rem_out = r[REM_W-1:0];
   end

endmodule

@@ src/mpeg_audio_frame_header_decode_unit.sv @@
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    sync, version/layer and rate bytes
// rsp      out        rsp_valid/stall    status, decoded fields, frame length
//
// One header enters per cycle while req_stall is low, and its result passes through the stages below.
// The five register stages are decode, multiply, and three divider stages of
// four quotient bits each; the last divider stage loads the output register.
// A stalled output backs up only as far as the stages that are full.
// Reset is synchronous and clears the stage valid bits.
`include "mpeg_audio_frame_header_decode_unit_defines.svh"

module mpeg_audio_frame_header_decode_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_sync_byte,
   input  logic [7:0]  req_version_layer_byte,
   input  logic [7:0]  req_rate_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_version_code,
   output logic [1:0]  rsp_layer_index,
   output logic        rsp_crc_bit,
   output logic        rsp_padding_bit,
   output logic [8:0]  rsp_bitrate_kbps,
   output logic [15:0] rsp_sample_rate_hz,
   output logic [11:0] rsp_frame_bytes
);
   import mafhd_pkg::*;

   logic en1, en2, en3, en4, en_out;
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;

   info_type info1_in, info1_ff, info2_ff, info3_ff, info4_ff, info_out_ff;
   logic [PROD_W-1:0] prod1_in, prod1_ff;
   logic [NUM_W-1:0]  num2_in, num2_ff;
   logic [REM_W-1:0]  rem3_in, rem3_ff, rem4_in, rem4_ff, rem5_unused;
   logic [7:0]        low3_ff;
   logic [3:0]        low4_ff;
   logic [3:0]        q3_in, q4_in, q5_in;
   logic [3:0]        q3_ff;
   logic [7:0]        q4_ff;
   logic [11:0]       frame_in, frame_ff;

   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en4       = !v4_ff || en_out;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_comb begin
      logic       fam;
      logic [1:0] ver;
      logic [1:0] layer;
      logic [3:0] bidx;
      logic [1:0] fidx;
      status_type st;
      logic [PROD_W-1:0] prod_full;
      ver   = req_version_layer_byte[4:3];
      layer = LAYER_NONE - req_version_layer_byte[2:1];
      bidx  = req_rate_byte[7:4];
      fidx  = req_rate_byte[3:2];
      fam   = (ver != VER_MPEG1);
      priority if (req_sync_byte != 8'hFF || req_version_layer_byte[7:5] != 3'b111 ||
                   bidx == 4'hF) begin
         st = ST_NO_SYNC;
      end else if (ver == VER_RESERVED) begin
         st = ST_RSVD_VER;
      end else if (layer == LAYER_NONE) begin
         st = ST_RSVD_LAYER;
      end else if (bidx == 4'd0) begin
         st = ST_ZERO_RATE;
      end else if (fidx == FREQ_NONE) begin
         st = ST_RSVD_FREQ;
      end else begin
         st = ST_OK;
      end
      info1_in = '0;
      info1_in.status = st;
      if (st == ST_OK) begin
         info1_in.ver   = ver;
         info1_in.layer = layer;
         info1_in.crc   = req_version_layer_byte[0];
         info1_in.pad   = req_rate_byte[1];
         info1_in.kbps  = kbps_lookup(fam, layer, bidx);
         info1_in.hz    = hz_lookup(ver, fidx);
      end
      prod_full = PROD_W'(coef_lookup(fam, layer)) * PROD_W'(info1_in.kbps);
      prod1_in  = prod_full;
   end

   assign num2_in = NUM_W'(prod1_ff) * NUM_W'(KILO);

   mafhd_div_step u_div3 (
      .rem_in  (REM_W'(num2_ff[NUM_W-1:QUO_W])),
      .low_in  (num2_ff[QUO_W-1:QUO_W-DIV_BITS]),
      .divisor (info2_ff.hz),
      .rem_out (rem3_in),
      .quo_out (q3_in)
   );

   mafhd_div_step u_div4 (
      .rem_in  (rem3_ff),
      .low_in  (low3_ff[7:4]),
      .divisor (info3_ff.hz),
      .rem_out (rem4_in),
      .quo_out (q4_in)
   );

   mafhd_div_step u_div5 (
      .rem_in  (rem4_ff),
      .low_in  (low4_ff),
      .divisor (info4_ff.hz),
      .rem_out (rem5_unused),
      .quo_out (q5_in)
   );

   always_comb begin
      logic [12:0] fsum;
      fsum = {1'b0, q4_ff, q5_in} + 13'(info4_ff.pad);
      if (info4_ff.status != ST_OK) begin
         frame_in = '0;
      end else if (info4_ff.layer == LAYER_I) begin
         frame_in = {fsum[9:0], 2'b00};
      end else begin
         frame_in = fsum[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en_out) rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         info1_ff <= info1_in;
         prod1_ff <= prod1_in;
      end
      if (en2) begin
         info2_ff <= info1_ff;
         num2_ff  <= num2_in;
      end
      if (en3) begin
         info3_ff <= info2_ff;
         rem3_ff  <= rem3_in;
         low3_ff  <= num2_ff[7:0];
         q3_ff    <= q3_in;
      end
      if (en4) begin
         info4_ff <= info3_ff;
         rem4_ff  <= rem4_in;
         low4_ff  <= low3_ff[3:0];
         q4_ff    <= {q3_ff, q4_in};
      end
      if (en_out) begin
         info_out_ff <= info4_ff;
         frame_ff    <= frame_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = info_out_ff.status;
   assign rsp_version_code   = info_out_ff.ver;
   assign rsp_layer_index    = info_out_ff.layer;
   assign rsp_crc_bit        = info_out_ff.crc;
   assign rsp_padding_bit    = info_out_ff.pad;
   assign rsp_bitrate_kbps   = info_out_ff.kbps;
   assign rsp_sample_rate_hz = info_out_ff.hz;
   assign rsp_frame_bytes    = frame_ff;

   `MAFHD_ASSERT_SAME(a_fail_zeroed, clock, reset, rsp_valid && rsp_status != ST_OK,
      rsp_frame_bytes == 12'd0 && rsp_bitrate_kbps == 9'd0 && rsp_sample_rate_hz == 16'd0)
   `MAFHD_ASSERT_SAME(a_ok_has_rate, clock, reset, rsp_valid && rsp_status == ST_OK,
      rsp_sample_rate_hz != 16'd0 && rsp_bitrate_kbps != 9'd0 && rsp_version_code != VER_RESERVED)
   `MAFHD_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, v1_ff)

endmodule

@@ verif/header_decode_scoreboard.sv @@
module header_decode_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_sync_byte,
   input  logic [7:0]  req_version_layer_byte,
   input  logic [7:0]  req_rate_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [1:0]  rsp_version_code,
   input  logic [1:0]  rsp_layer_index,
   input  logic        rsp_crc_bit,
   input  logic        rsp_padding_bit,
   input  logic [8:0]  rsp_bitrate_kbps,
   input  logic [15:0] rsp_sample_rate_hz,
   input  logic [11:0] rsp_frame_bytes,
   output int          mismatch_count,
   output int          pending_count
);
   import mafhd_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [1:0]  ver;
      logic [1:0]  layer;
      logic        crc;
      logic        pad;
      logic [8:0]  kbps;
      logic [15:0] hz;
      logic [11:0] frame;
   } frame_info_type;

   int unsigned bitrate_table [2][3][16] = '{
      '{
         '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
         '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
         '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
      },
      '{
         '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
         '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
         '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
      }
   };

   int unsigned sample_rate_table [4][3] = '{
      '{11025, 12000, 8000},
      '{0, 0, 0},
      '{22050, 24000, 16000},
      '{44100, 48000, 32000}
   };

   frame_info_type expected_frames [$];
   int             mismatches = 0;
   int             waiting = 0;

   assign mismatch_count = mismatches;
   assign pending_count  = waiting;

   function automatic frame_info_type decode_header(input logic [7:0] b0,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2);
      frame_info_type info;
      logic [1:0]  ver;
      logic [1:0]  layer;
      logic [3:0]  bidx;
      logic [1:0]  fidx;
      logic        family;
      int unsigned kbps;
      int unsigned hz;
      int unsigned coef;
      int unsigned frame;
      info = '0;
      ver = b1[4:3];
      layer = LAYER_NONE - b1[2:1];
      bidx = b2[7:4];
      fidx = b2[3:2];
      if (b0 != 8'hFF || b1[7:5] != 3'b111 || bidx == 4'hF) begin
         info.status = ST_NO_SYNC;
      end else if (ver == VER_RESERVED) begin
         info.status = ST_RSVD_VER;
      end else if (layer == LAYER_NONE) begin
         info.status = ST_RSVD_LAYER;
      end else if (bidx == 4'd0) begin
         info.status = ST_ZERO_RATE;
      end else if (fidx == FREQ_NONE) begin
         info.status = ST_RSVD_FREQ;
      end else begin
         family = (ver != VER_MPEG1);
         kbps = bitrate_table[family][layer][bidx];
         hz = sample_rate_table[ver][fidx];
         if (layer == LAYER_I) begin
            coef = 12;
         end else if (layer == LAYER_II || !family) begin
            coef = 144;
         end else begin
            coef = 72;
         end
         frame = coef * kbps * 1000 / hz + b2[1];
         if (layer == LAYER_I) begin
            frame = frame * 4;
         end
         info.status = ST_OK;
         info.ver = ver;
         info.layer = layer;
         info.crc = b1[0];
         info.pad = b2[1];
         info.kbps = kbps[8:0];
         info.hz = hz[15:0];
         info.frame = frame[11:0];
      end
      return info;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      frame_info_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_frames.push_back(decode_header(req_sync_byte, req_version_layer_byte,
                                                    req_rate_byte));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result transfer, expected none, actual status %0d",
                        $time, rsp_status);
            end else begin
               want = expected_frames.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("version_code", want.ver, rsp_version_code);
               check_field("layer_index", want.layer, rsp_layer_index);
               check_field("crc_bit", want.crc, rsp_crc_bit);
               check_field("padding_bit", want.pad, rsp_padding_bit);
               check_field("bitrate_kbps", want.kbps, rsp_bitrate_kbps);
               check_field("sample_rate_hz", want.hz, rsp_sample_rate_hz);
               check_field("frame_bytes", want.frame, rsp_frame_bytes);
            end
         end
         waiting <= expected_frames.size();
      end
   end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
   import mafhd_pkg::*;

   localparam logic [1:0] VER_MPEG25 = 2'd0;
   localparam logic [1:0] VER_MPEG2  = 2'd2;
   localparam int RANDOM_HEADERS = 1628;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_sync_byte = 8'd0;
   logic [7:0]  req_version_layer_byte = 8'd0;
   logic [7:0]  req_rate_byte = 8'd0;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_version_code;
   logic [1:0]  rsp_layer_index;
   logic        rsp_crc_bit;
   logic        rsp_padding_bit;
   logic [8:0]  rsp_bitrate_kbps;
   logic [15:0] rsp_sample_rate_hz;
   logic [11:0] rsp_frame_bytes;
   int          mismatch_count;
   int          pending_count;
   bit          quiet = 1'b0;

   logic [23:0] directed_headers [0:21] = '{
      24'h000000, 24'hFFFFFF, 24'hFEFB90, 24'hFF7B90, 24'hFFFBF0, 24'hFFEA10,
      24'hFFE090, 24'hFFF990, 24'hFFFB00, 24'hFFFB9C, 24'hFFFB90, 24'hFFFA92,
      24'hFFFF1B, 24'hFFFEEA, 24'hFFFD14, 24'hFFFCE8, 24'hFFF6E4, 24'hFFF5A2,
      24'hFFF3E9, 24'hFFE4EA, 24'hFFE714, 24'hFFE2D6
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 9);
   end

   mpeg_audio_frame_header_decode_unit DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_sync_byte          (req_sync_byte),
      .req_version_layer_byte (req_version_layer_byte),
      .req_rate_byte          (req_rate_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_version_code       (rsp_version_code),
      .rsp_layer_index        (rsp_layer_index),
      .rsp_crc_bit            (rsp_crc_bit),
      .rsp_padding_bit        (rsp_padding_bit),
      .rsp_bitrate_kbps       (rsp_bitrate_kbps),
      .rsp_sample_rate_hz     (rsp_sample_rate_hz),
      .rsp_frame_bytes        (rsp_frame_bytes)
   );

   header_decode_scoreboard scoreboard (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_sync_byte          (req_sync_byte),
      .req_version_layer_byte (req_version_layer_byte),
      .req_rate_byte          (req_rate_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_version_code       (rsp_version_code),
      .rsp_layer_index        (rsp_layer_index),
      .rsp_crc_bit            (rsp_crc_bit),
      .rsp_padding_bit        (rsp_padding_bit),
      .rsp_bitrate_kbps       (rsp_bitrate_kbps),
      .rsp_sample_rate_hz     (rsp_sample_rate_hz),
      .rsp_frame_bytes        (rsp_frame_bytes),
      .mismatch_count         (mismatch_count),
      .pending_count          (pending_count)
   );

   task automatic send_header(input logic [23:0] header);
      if (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_sync_byte, req_version_layer_byte, req_rate_byte} <= header;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [23:0] random_header;
      logic [1:0] ver;
      int unsigned pick;
      pick = $urandom_range(99);
      // Most headers are well formed so that the table lookups and the divider get exercised.
      if (pick < 70) begin
         case ($urandom_range(2))
            0: ver = VER_MPEG25;
            1: ver = VER_MPEG2;
            default: ver = VER_MPEG1;
         endcase
         return {8'hFF, 3'b111, ver, 2'($urandom_range(1, 3)), 1'($urandom_range(1)),
                 4'($urandom_range(1, 14)), 2'($urandom_range(2)), 2'($urandom_range(3))};
      end else if (pick < 85) begin
         return {8'hFF, 3'b111, 5'($urandom), 8'($urandom)};
      end
      return 24'($urandom);
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_headers[i]) begin
         send_header(directed_headers[i]);
      end
      drain_results();
      for (int n = 0; n < RANDOM_HEADERS; n++) begin
         quiet = (n >= 700 && n < 1000);
         send_header(random_header());
         if (n == 400 || n == 1200) begin
            drain_results();
         end
      end
      quiet = 1'b0;
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ mpeg_audio_frame_header_decode_unit.f @@
+incdir+src
src/mafhd_pkg.sv
src/mafhd_div_step.sv
src/mpeg_audio_frame_header_decode_unit.sv
verif/header_decode_scoreboard.sv
verif/tb_top.sv
